>>> rtl/core/exti_pkg.sv
package exti_pkg;

  // Fixed sizes of the block.
  localparam int LINE_COUNT = 16;
  localparam int PORT_COUNT = 4;
  localparam int PIN_W      = 16;
  localparam int ROUTE_W    = 2;
  localparam int IRQ_W      = 7;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  // Item kinds; the fourth code has no meaning and changes nothing.
  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_TRIGGER = 2'd2
  } kind_e_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROUTE   = 2'd0,
    CFG_RISE_EN = 2'd1,
    CFG_FALL_EN = 2'd2,
    CFG_UNMASK  = 2'd3
  } cfg_reg_e_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PIN_W-1:0] port_a_pins;
    logic [PIN_W-1:0] port_b_pins;
    logic [PIN_W-1:0] port_c_pins;
    logic [PIN_W-1:0] port_d_pins;
    logic [PIN_W-1:0] line_mask;
  } in_item_t;

  typedef struct packed {
    logic [PIN_W-1:0] pending_lines;
    logic [IRQ_W-1:0] irq_vector;
  } out_item_t;

  // Control shared by every lane for the item being accepted.
  typedef struct packed {
    logic       accept;
    logic [1:0] kind;
  } lane_ctl_t;

  // Handshake control for the merging stage.
  typedef struct packed {
    logic load;
    logic out_stall;
  } merge_ctl_t;

endpackage

>>> rtl/core/external_interrupt_line_controller_core.sv
// External interrupt line controller: sixteen lines, each fed by pin n of one
// of four ports, detect enabled rising and falling edges at pin sample ticks
// and hold sticky pending bits, which software can also set (trigger) or
// clear (write one to clear) by mask. Every item gives one result item with
// the pending bits and the grouped unmasked requests. One lane per line
// works in parallel and a merging stage builds the result register, so an
// item is taken every cycle and its result appears in the next cycle; the
// only wait is a result register held by out_stall. The user must write
// configuration (cfg_wr_en, cfg_index, cfg_wdata) only while idle; the
// block does not enforce it; all but the result item register reset to zero.
module external_interrupt_line_controller_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  exti_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_stall,
  output exti_pkg::out_item_t                 out_item,
  input  logic                                cfg_wr_en,
  input  logic [exti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [exti_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import exti_pkg::*;

  logic [2*PIN_W-1:0] route_r;
  logic [PIN_W-1:0]   rise_en_r;
  logic [PIN_W-1:0]   fall_en_r;
  logic [PIN_W-1:0]   unmask_r;

  logic                  accept;
  lane_ctl_t             lane_ctl;
  merge_ctl_t            merge_ctl;
  logic [LINE_COUNT-1:0] lane_pending;
  logic [PORT_COUNT-1:0] lane_pins [LINE_COUNT];
  logic [PIN_W-1:0]      port_pins [4];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      route_r   <= '0;
      rise_en_r <= '0;
      fall_en_r <= '0;
      unmask_r  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_e_t'(cfg_index))
        CFG_ROUTE:   route_r   <= cfg_wdata;
        CFG_RISE_EN: rise_en_r <= cfg_wdata[PIN_W-1:0];
        CFG_FALL_EN: fall_en_r <= cfg_wdata[PIN_W-1:0];
        CFG_UNMASK:  unmask_r  <= cfg_wdata[PIN_W-1:0];
        default:     route_r   <= route_r;
      endcase
    end
  end

  // Input is taken unless a finished result is still waiting.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign lane_ctl.accept     = accept;
  assign lane_ctl.kind       = in_item.kind;
  assign merge_ctl.load      = accept;
  assign merge_ctl.out_stall = out_stall;

  // Give each lane its pin from every port.
  always_comb begin
    port_pins[0] = in_item.port_a_pins;
    port_pins[1] = in_item.port_b_pins;
    port_pins[2] = in_item.port_c_pins;
    port_pins[3] = in_item.port_d_pins;
    for (int l = 0; l < LINE_COUNT; l++) begin
      for (int p = 0; p < PORT_COUNT; p++) begin
        lane_pins[l][p] = port_pins[p][l];
      end
    end
  end

  // One lane per line.
  for (genvar g = 0; g < LINE_COUNT; g++) begin : g_lane
    exti_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (lane_ctl),
      .port_pins   (lane_pins[g]),
      .route       (route_r[ROUTE_W*g +: ROUTE_W]),
      .rise_en     (rise_en_r[g]),
      .fall_en     (fall_en_r[g]),
      .mask_bit    (in_item.line_mask[g]),
      .pending_nxt (lane_pending[g])
    );
  end

  exti_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (merge_ctl),
    .lane_pending (lane_pending),
    .unmask       (unmask_r),
    .out_valid    (out_valid),
    .out_item     (out_item)
  );

  // Input is only held back by a waiting result.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  // Every accepted item leaves a result behind.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // A clear leaves none of the masked lines pending.
  a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind == KIND_CLEAR) |=>
      ((out_item.pending_lines & $past(in_item.line_mask)) == '0))
    else $error("cleared line still pending");

  // A software trigger leaves all masked lines pending.
  a_trigger_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind == KIND_TRIGGER) |=>
      ((out_item.pending_lines & $past(in_item.line_mask))
        == $past(in_item.line_mask)))
    else $error("triggered line not pending");

endmodule

>>> rtl/core/exti_lane.sv
module exti_lane (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  exti_pkg::lane_ctl_t                    ctl,
  input  logic [exti_pkg::PORT_COUNT-1:0]        port_pins,
  input  logic [exti_pkg::ROUTE_W-1:0]           route,
  input  logic                                   rise_en,
  input  logic                                   fall_en,
  input  logic                                   mask_bit,
  output logic                                   pending_nxt
);
  import exti_pkg::*;

  logic prev_r;
  logic prev_nxt;
  logic pending_r;
  logic level;
  logic rise;
  logic fall;

  // Pick the routed port's pin; a route to an absent port reads low.
  always_comb begin
    level = 1'b0;
    if (int'(route) < PORT_COUNT) begin
      level = port_pins[route];
    end
  end

  assign rise = level & ~prev_r & rise_en;
  assign fall = ~level & prev_r & fall_en;

  // Next pending bit and level memory for one item.
  always_comb begin
    prev_nxt    = prev_r;
    pending_nxt = pending_r;
    unique case (ctl.kind)
      KIND_TICK: begin
        prev_nxt    = level;
        pending_nxt = pending_r | rise | fall;
      end
      KIND_CLEAR:   pending_nxt = pending_r & ~mask_bit;
      KIND_TRIGGER: pending_nxt = pending_r | mask_bit;
      default:      pending_nxt = pending_r;
    endcase
  end

  // State moves only when an item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= 1'b0;
      pending_r <= 1'b0;
    end else if (ctl.accept) begin
      prev_r    <= prev_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

>>> rtl/core/exti_merge.sv
module exti_merge (
  input  logic                              clk,
  input  logic                              rst_n,
  input  exti_pkg::merge_ctl_t              ctl,
  input  logic [exti_pkg::LINE_COUNT-1:0]   lane_pending,
  input  logic [exti_pkg::PIN_W-1:0]        unmask,
  output logic                              out_valid,
  output exti_pkg::out_item_t               out_item
);
  import exti_pkg::*;

  logic [PIN_W-1:0] pending_full;
  logic [PIN_W-1:0] active;
  out_item_t        item_nxt;
  out_item_t        item_r;
  logic             valid_r;
  logic             valid_nxt;

  // Gather the lanes and group the unmasked lines onto the request outputs.
  always_comb begin
    pending_full                   = '0;
    pending_full[LINE_COUNT-1:0]   = lane_pending;
    active                         = pending_full & unmask;
    item_nxt.pending_lines         = pending_full;
    item_nxt.irq_vector            = '0;
    item_nxt.irq_vector[4:0]       = active[4:0];
    item_nxt.irq_vector[5]         = |active[9:5];
    item_nxt.irq_vector[6]         = |active[15:10];
  end

  // The result register holds until the item is taken downstream.
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.load) begin
      valid_nxt = 1'b1;
    end else if (!ctl.out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

>>> tb/tb_top.sv
module tb_top;
  import exti_pkg::*;

  // The fourth kind code has no meaning; the block must leave its state alone.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Port selections held in each two-bit line route.
  localparam logic [ROUTE_W-1:0] PORT_A = 2'd0;
  localparam logic [ROUTE_W-1:0] PORT_B = 2'd1;
  localparam logic [ROUTE_W-1:0] PORT_C = 2'd2;
  localparam logic [ROUTE_W-1:0] PORT_D = 2'd3;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 4;
  localparam int PRINT_CAP    = 200;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_item;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Copy of the configuration and of the line state kept by the testbench.
  logic [31:0] route_copy;
  logic [15:0] rise_en_copy;
  logic [15:0] fall_en_copy;
  logic [15:0] unmask_copy;
  logic [15:0] last_levels;
  logic [15:0] pending_lines_now;

  out_item_t status_expect_q[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        idle_on = 1'b0;

  external_interrupt_line_controller_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a period of twelve units.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit in case the block stops responding.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < PRINT_CAP)
      $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)", what, got, want,
               cycle_count);
    error_count++;
  endtask

  // Works out the pending bits and grouped requests that one accepted item
  // leaves behind, and queues them as the next expected result.
  task automatic advance_line_model(input in_item_t it);
    logic [15:0] levels;
    logic [15:0] pins;
    logic [15:0] rises;
    logic [15:0] falls;
    logic [15:0] active;
    out_item_t   res;
    int          i;
    levels = '0;
    for (i = 0; i < LINE_COUNT; i++) begin
      case (route_copy[2*i +: 2])
        PORT_A:  pins = it.port_a_pins;
        PORT_B:  pins = it.port_b_pins;
        PORT_C:  pins = it.port_c_pins;
        default: pins = it.port_d_pins;
      endcase
      levels[i] = pins[i];
    end
    case (it.kind)
      KIND_TICK: begin
        rises = levels & ~last_levels & rise_en_copy;
        falls = ~levels & last_levels & fall_en_copy;
        pending_lines_now = pending_lines_now | rises | falls;
        last_levels = levels;
      end
      KIND_CLEAR: begin
        pending_lines_now = pending_lines_now & ~it.line_mask;
      end
      KIND_TRIGGER: begin
        pending_lines_now = pending_lines_now | it.line_mask;
      end
      default: begin
      end
    endcase
    active = pending_lines_now & unmask_copy;
    res.pending_lines = pending_lines_now;
    res.irq_vector    = {|active[15:10], |active[9:5], active[4:0]};
    status_expect_q.push_back(res);
  endtask

  // Compares every accepted result item with the oldest expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (status_expect_q.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_item), 32'd0);
      end else begin
        want = status_expect_q.pop_front();
        if (out_item.pending_lines !== want.pending_lines)
          report_mismatch("pending_lines", 32'(out_item.pending_lines),
                          32'(want.pending_lines));
        if (out_item.irq_vector !== want.irq_vector)
          report_mismatch("irq_vector", 32'(out_item.irq_vector),
                          32'(want.irq_vector));
      end
    end
  end

  // The receiving side stalls in random bursts while idling is allowed.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Offers one item, with an optional gap before it, and waits for it to be taken.
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_line_model(it);
  endtask

  // Holds the sender back until every expected result has come out.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (status_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Register writes happen only once the block has gone quiet.
  task automatic write_reg(input cfg_reg_e_t idx, input logic [31:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_ROUTE:   route_copy   = value;
      CFG_RISE_EN: rise_en_copy = value[15:0];
      CFG_FALL_EN: fall_en_copy = value[15:0];
      CFG_UNMASK:  unmask_copy  = value[15:0];
      default: begin
      end
    endcase
  endtask

  function automatic in_item_t build_item(input logic [1:0] kind, input logic [15:0] pa,
                                          input logic [15:0] pb, input logic [15:0] pc,
                                          input logic [15:0] pd, input logic [15:0] mask);
    in_item_t it;
    it.kind        = kind;
    it.port_a_pins = pa;
    it.port_b_pins = pb;
    it.port_c_pins = pc;
    it.port_d_pins = pd;
    it.line_mask   = mask;
    return it;
  endfunction

  // Per-line masks favour the all-clear and all-set extremes now and then.
  function automatic logic [15:0] random_lines();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_route();
    case ($urandom_range(0, 6))
      0:       return 32'h0000_0000;
      1:       return 32'h5555_5555;
      2:       return 32'hAAAA_AAAA;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly pin ticks, so edges keep arriving, with commands mixed in.
  function automatic in_item_t random_item();
    in_item_t it;
    int       sel;
    sel = $urandom_range(0, 99);
    it  = build_item(KIND_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), random_lines());
    if ($urandom_range(0, 9) == 0) begin
      it.port_a_pins = random_lines();
      it.port_b_pins = it.port_a_pins;
      it.port_c_pins = it.port_a_pins;
      it.port_d_pins = it.port_a_pins;
    end
    if (sel >= 95)
      it.kind = KIND_UNUSED;
    else if (sel >= 85)
      it.kind = KIND_TRIGGER;
    else if (sel >= 70)
      it.kind = KIND_CLEAR;
    return it;
  endfunction

  // A line that is high at the first tick after reset counts as a rising edge.
  task automatic test_first_tick_edge();
    write_reg(CFG_ROUTE, 32'h0000_0000);
    write_reg(CFG_RISE_EN, 32'h0000_FFFF);
    write_reg(CFG_UNMASK, 32'h0000_FFFF);
    send_item(build_item(KIND_TICK, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(build_item(KIND_TICK, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
  endtask

  // Clears and triggers by mask; pins on commands are ignored; the unused kind
  // only reports the state.
  task automatic test_commands();
    send_item(build_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    send_item(build_item(KIND_TRIGGER, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h8001));
    send_item(build_item(KIND_CLEAR, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001));
    send_item(build_item(KIND_UNUSED, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(build_item(KIND_TRIGGER, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    send_item(build_item(KIND_CLEAR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(build_item(KIND_CLEAR, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
  endtask

  // Ports B, C and D in turn feed every line, giving falling and rising edges.
  task automatic test_port_routes();
    write_reg(CFG_FALL_EN, 32'h0000_FFFF);
    write_reg(CFG_ROUTE, 32'h5555_5555);
    send_item(build_item(KIND_TICK, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000));
    send_item(build_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    write_reg(CFG_ROUTE, 32'hAAAA_AAAA);
    send_item(build_item(KIND_TICK, 16'h0000, 16'hFFFF, 16'h5A5A, 16'h0000, 16'h0000));
    send_item(build_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    write_reg(CFG_ROUTE, 32'hFFFF_FFFF);
    send_item(build_item(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hA5A5, 16'h0000));
  endtask

  // Grouping of unmasked pending lines onto the interrupt outputs.
  task automatic test_irq_groups();
    send_item(build_item(KIND_TRIGGER, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF));
    write_reg(CFG_UNMASK, 32'h0000_001F);
    send_item(build_item(KIND_TRIGGER, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    write_reg(CFG_UNMASK, 32'h0000_03E0);
    send_item(build_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100));
    write_reg(CFG_UNMASK, 32'h0000_FC00);
    send_item(build_item(KIND_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7C00));
    write_reg(CFG_UNMASK, 32'h0000_0000);
    send_item(build_item(KIND_UNUSED, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
  endtask

  // Random settings per phase, random items, and one full pause mid-phase.
  task automatic test_random_phases(input int phases, input int per_phase);
    int p;
    int n;
    for (p = 0; p < phases; p++) begin
      write_reg(CFG_ROUTE, random_route());
      write_reg(CFG_RISE_EN, {16'h0000, random_lines()});
      write_reg(CFG_FALL_EN, {16'h0000, random_lines()});
      write_reg(CFG_UNMASK, {16'h0000, random_lines()});
      for (n = 0; n < per_phase; n++) begin
        if (n == per_phase / 2)
          wait_for_results();
        send_item(random_item());
      end
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_item           = '0;
    cfg_wr_en         = 1'b0;
    cfg_index         = CFG_ROUTE;
    cfg_wdata         = '0;
    route_copy        = '0;
    rise_en_copy      = '0;
    fall_en_copy      = '0;
    unmask_copy       = '0;
    last_levels       = '0;
    pending_lines_now = '0;
    idle_on           = 1'b1;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_first_tick_edge();
    test_commands();
    test_port_routes();
    test_irq_groups();
    test_random_phases(8, 100);
    // Closing stretch runs at full rate on both sides.
    idle_on = 1'b0;
    test_random_phases(1, 100);
    wait_for_results();

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
